// File: hdl/sff_pkg.sv
// Shared types and constants of the streaming FIR filter.
package sff_pkg;

    localparam int DATA_W       = 16;
    localparam int COEF_IDX_W   = 6;
    localparam int CFG_W        = 7;
    localparam int DEFAULT_TAPS = 64;

    localparam logic [CFG_W-1:0] TAP_COUNT_RESET = 7'd64;

    localparam logic FUNC_COEF   = 1'b0;
    localparam logic FUNC_SAMPLE = 1'b1;

    // control from the sequencer to the multiply-accumulate unit
    typedef struct packed {
        logic clear;
        logic mul_en;
    } mac_ctrl_t;

endpackage

// File: hdl/sff_if.sv
// Valid/ready channel interfaces for filter input items and filter results.
interface sff_in_if import sff_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic                     func;
    logic [COEF_IDX_W-1:0]    coef_index;
    logic signed [DATA_W-1:0] coef_value;
    logic signed [DATA_W-1:0] sample;

    modport source (output valid, func, coef_index, coef_value, sample, input ready);
    modport sink   (input valid, func, coef_index, coef_value, sample, output ready);
endinterface

interface sff_out_if import sff_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] filtered_sample;
    logic                     saturated;

    modport source (output valid, filtered_sample, saturated, input ready);
    modport sink   (input valid, filtered_sample, saturated, output ready);
endinterface

// File: hdl/sff_mac.sv
// Shared multiply-accumulate unit: registered 16x16 product, then accumulate.
module sff_mac import sff_pkg::*; #(
    parameter int TAPS = DEFAULT_TAPS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  mac_ctrl_t                        ctrl,
    input  logic signed [DATA_W-1:0]         coef,
    input  logic signed [DATA_W-1:0]         hist,
    output logic signed [33+$clog2(TAPS)-1:0] acc,
    output logic                             pending
);

    localparam int ACC_W  = 33 + $clog2(TAPS);
    localparam int PROD_W = 2 * DATA_W;

    logic signed [PROD_W-1:0] prod_reg;
    logic                     prod_vld_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  prod_ext;

    always_ff @(posedge clk)
    begin
        if (ctrl.mul_en)
        begin
            prod_reg <= coef * hist;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_vld_reg <= 1'b0;
        end
        else
        begin
            prod_vld_reg <= ctrl.mul_en;
        end
    end

    assign prod_ext = {{(ACC_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};

    always_ff @(posedge clk)
    begin
        if (ctrl.clear)
        begin
            acc_reg <= '0;
        end
        else if (prod_vld_reg)
        begin
            acc_reg <= acc_reg + prod_ext;
        end
    end

    assign acc     = acc_reg;
    assign pending = prod_vld_reg;

endmodule

// File: hdl/streaming_fir_filter_unit.sv
// Direct-form FIR filter: one shared multiply-accumulate stepped over the taps.
// A coefficient write (func 0) is stored in the coefficient memory. A sample
// (func 1) starts a sweep over the active taps: one tap a cycle is read from the
// coefficient and history memories into the single multiplier, then the read
// and product registers drain, and a rounding step rounds and saturates.
// The input is not ready while a sample is worked on. The result sits in an
// output register, so a new item may be taken while it waits for transfer;
// a finished sum waits in the rounding step if that register is still full.
// No clearing pass follows reset: a fill count masks history not yet written.
module streaming_fir_filter_unit import sff_pkg::*; #(
    parameter int TAPS = DEFAULT_TAPS
) (
    input  logic             clk,
    input  logic             rst_n,
    sff_in_if.sink           in_ch,
    sff_out_if.source        out_ch,
    input  logic             cfg_we,
    input  logic [CFG_W-1:0] cfg_wdata
);

    localparam int IDX_W = $clog2(TAPS);
    localparam int CNT_W = $clog2(TAPS + 1);
    localparam int ACC_W = 33 + $clog2(TAPS);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_RUN   = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_ROUND = 2'd3;

    logic [1:0]               state_reg, state_next;
    logic [CFG_W-1:0]         tap_count_reg;
    logic [CNT_W-1:0]         taps_reg;
    logic [CNT_W-1:0]         taps_eff;
    logic [CNT_W-1:0]         fill_reg;
    logic [IDX_W-1:0]         newest_reg;
    logic [IDX_W-1:0]         tap_reg;
    logic [IDX_W-1:0]         slot_reg;
    logic                     rd_vld_reg;
    logic                     live_reg;
    logic signed [DATA_W-1:0] coef_rd_reg;
    logic signed [DATA_W-1:0] hist_rd_reg;
    logic signed [DATA_W-1:0] coef_mem [TAPS];
    logic signed [DATA_W-1:0] hist_mem [TAPS];
    logic                     out_valid_reg;
    logic signed [DATA_W-1:0] out_data_reg;
    logic                     out_sat_reg;

    logic                     in_xfer;
    logic                     sample_xfer;
    logic                     coef_we;
    logic                     last_tap;
    logic                     out_free;
    mac_ctrl_t                mac_ctrl;
    logic signed [ACC_W-1:0]  acc;
    logic                     mac_pending;
    logic signed [ACC_W:0]    round_sum;
    logic signed [ACC_W:0]    round_q;
    logic                     in_range;
    logic signed [DATA_W-1:0] round_data;

    assign in_ch.ready = (state_reg == ST_IDLE);
    assign in_xfer     = in_ch.valid && in_ch.ready;
    assign sample_xfer = in_xfer && (in_ch.func == FUNC_SAMPLE);
    assign coef_we     = in_xfer && (in_ch.func == FUNC_COEF)
                         && (int'(in_ch.coef_index) < TAPS);
    assign last_tap    = (CNT_W'(tap_reg) == taps_reg - CNT_W'(1));
    assign out_free    = !out_valid_reg || out_ch.ready;

    // clamp tap_count to 1..TAPS
    always_comb
    begin
        if (tap_count_reg == '0)
        begin
            taps_eff = CNT_W'(1);
        end
        else if (int'(tap_count_reg) > TAPS)
        begin
            taps_eff = CNT_W'(TAPS);
        end
        else
        begin
            taps_eff = CNT_W'(tap_count_reg);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (sample_xfer)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (last_tap)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!rd_vld_reg && !mac_pending)
                begin
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            tap_count_reg <= TAP_COUNT_RESET;
            taps_reg      <= CNT_W'(1);
            fill_reg      <= '0;
            newest_reg    <= '0;
            tap_reg       <= '0;
            slot_reg      <= '0;
            rd_vld_reg    <= 1'b0;
            live_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            rd_vld_reg <= (state_reg == ST_RUN);
            live_reg   <= (CNT_W'(tap_reg) < fill_reg);
            if (cfg_we)
            begin
                tap_count_reg <= cfg_wdata;
            end
            if (sample_xfer)
            begin
                taps_reg   <= taps_eff;
                tap_reg    <= '0;
                slot_reg   <= newest_reg;
                newest_reg <= (newest_reg == '0) ? IDX_W'(TAPS - 1)
                                                 : newest_reg - IDX_W'(1);
                if (int'(fill_reg) < TAPS)
                begin
                    fill_reg <= fill_reg + CNT_W'(1);
                end
            end
            else if (state_reg == ST_RUN)
            begin
                tap_reg  <= tap_reg + IDX_W'(1);
                slot_reg <= (slot_reg == IDX_W'(TAPS - 1)) ? '0 : slot_reg + IDX_W'(1);
            end
            if (state_reg == ST_ROUND && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // coefficient and history memories, one write and one registered read each
    always_ff @(posedge clk)
    begin
        if (coef_we)
        begin
            coef_mem[IDX_W'(in_ch.coef_index)] <= in_ch.coef_value;
        end
        coef_rd_reg <= coef_mem[tap_reg];
    end

    always_ff @(posedge clk)
    begin
        if (sample_xfer)
        begin
            hist_mem[newest_reg] <= in_ch.sample;
        end
        hist_rd_reg <= hist_mem[slot_reg];
    end

    assign mac_ctrl.clear  = sample_xfer;
    assign mac_ctrl.mul_en = rd_vld_reg;

    sff_mac #(
        .TAPS (TAPS)
    ) u_mac (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (mac_ctrl),
        .coef    (coef_rd_reg),
        .hist    (live_reg ? hist_rd_reg : '0),
        .acc     (acc),
        .pending (mac_pending)
    );

    // round half up, then clip when the bits above Q1.15 are not a sign extension
    assign round_sum  = {acc[ACC_W-1], acc} + (ACC_W+1)'(16384);
    assign round_q    = round_sum >>> 15;
    assign in_range   = (&round_q[ACC_W:DATA_W-1]) || !(|round_q[ACC_W:DATA_W-1]);
    assign round_data = in_range ? round_q[DATA_W-1:0]
                      : (round_q[ACC_W] ? {1'b1, {(DATA_W-1){1'b0}}}
                                        : {1'b0, {(DATA_W-1){1'b1}}});

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_ROUND && out_free)
        begin
            out_data_reg <= round_data;
            out_sat_reg  <= !in_range;
        end
    end

    assign out_ch.valid           = out_valid_reg;
    assign out_ch.filtered_sample = out_data_reg;
    assign out_ch.saturated       = out_sat_reg;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        int'(fill_reg) <= TAPS)
        else $error("history fill count above depth");

    a_tap_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_RUN |-> CNT_W'(tap_reg) < taps_reg)
        else $error("tap counter past active taps");

    a_sample_starts: assert property (@(posedge clk) disable iff (!rst_n)
        sample_xfer |=> state_reg == ST_RUN && tap_reg == '0)
        else $error("sample transfer did not start the tap sweep");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_ROUND)
        else $error("result shown without a rounding step");

    a_round_drained: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_ROUND |-> !rd_vld_reg && !mac_pending)
        else $error("rounding while products still in flight");

endmodule
